@@ sv/pfdm_pkg.sv @@
// pfdm_pkg: shared constants, micro-op and condition codes, control word
// types and the microcode program of the pulse frequency/duty meter.
// No dependencies; every other file of the block refers to it by scoped name.
package pfdm_pkg;

    // timer and measurement geometry
    localparam int CNT_BITS   = 16;
    localparam int AVG_DEPTH  = 8;
    localparam int AVG_IDX_W  = $clog2(AVG_DEPTH);
    localparam int AVG_CNT_W  = $clog2(AVG_DEPTH + 1);
    localparam int TICK_W     = 2 * CNT_BITS;
    localparam int FREQ_W     = 20;
    localparam int DUTY_W     = 7;
    localparam int LIMIT_W    = 16;
    localparam int CMD_W      = 2;
    localparam int SUM_W      = FREQ_W + AVG_IDX_W;
    localparam int MUL_W      = TICK_W + DUTY_W;
    localparam int DIV_W      = MUL_W + 1;
    localparam int DIV_IT_W   = $clog2(DIV_W + 1);
    localparam int DUTY_SCALE = 100;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = FREQ_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;
    localparam logic [FREQ_W-1:0]    TPS_RESET   = 20'd1000000;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 16'd500;

    // input commands
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OVF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // micro-ops
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
    localparam logic [OP_W-1:0] OP_FETCH    = 5'd1;
    localparam logic [OP_W-1:0] OP_ELAPSED  = 5'd2;
    localparam logic [OP_W-1:0] OP_PSUM     = 5'd3;
    localparam logic [OP_W-1:0] OP_LD_FREQ  = 5'd4;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd5;
    localparam logic [OP_W-1:0] OP_PUSH     = 5'd6;
    localparam logic [OP_W-1:0] OP_ACC      = 5'd7;
    localparam logic [OP_W-1:0] OP_LD_AVG   = 5'd8;
    localparam logic [OP_W-1:0] OP_AVG      = 5'd9;
    localparam logic [OP_W-1:0] OP_HIGH     = 5'd10;
    localparam logic [OP_W-1:0] OP_LD_DUTY  = 5'd11;
    localparam logic [OP_W-1:0] OP_DUTY     = 5'd12;
    localparam logic [OP_W-1:0] OP_SETPH    = 5'd13;
    localparam logic [OP_W-1:0] OP_OVF      = 5'd14;
    localparam logic [OP_W-1:0] OP_TICK     = 5'd15;
    localparam logic [OP_W-1:0] OP_OUT      = 5'd16;

    // jump conditions
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
    localparam logic [COND_W-1:0] C_NO_INPUT    = 4'd2;
    localparam logic [COND_W-1:0] C_CMD_OVF     = 4'd3;
    localparam logic [COND_W-1:0] C_CMD_TICK    = 4'd4;
    localparam logic [COND_W-1:0] C_CMD_UNUSED  = 4'd5;
    localparam logic [COND_W-1:0] C_PHASE1      = 4'd6;
    localparam logic [COND_W-1:0] C_P_ZERO      = 4'd7;
    localparam logic [COND_W-1:0] C_DIV_MORE    = 4'd8;
    localparam logic [COND_W-1:0] C_ACC_MORE    = 4'd9;
    localparam logic [COND_W-1:0] C_PERIOD_ZERO = 4'd10;
    localparam logic [COND_W-1:0] C_OUT_FULL    = 4'd11;

    // program addresses
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] A_FETCH   = 5'd0;
    localparam logic [PC_W-1:0] A_DISP_OV = 5'd1;
    localparam logic [PC_W-1:0] A_DISP_TK = 5'd2;
    localparam logic [PC_W-1:0] A_DISP_UN = 5'd3;
    localparam logic [PC_W-1:0] A_ELAPSED = 5'd4;
    localparam logic [PC_W-1:0] A_PSUM    = 5'd5;
    localparam logic [PC_W-1:0] A_LD_FREQ = 5'd6;
    localparam logic [PC_W-1:0] A_DIVF    = 5'd7;
    localparam logic [PC_W-1:0] A_PUSH    = 5'd8;
    localparam logic [PC_W-1:0] A_ACC     = 5'd9;
    localparam logic [PC_W-1:0] A_LD_AVG  = 5'd10;
    localparam logic [PC_W-1:0] A_DIVA    = 5'd11;
    localparam logic [PC_W-1:0] A_AVG     = 5'd12;
    localparam logic [PC_W-1:0] A_FALL    = 5'd13;
    localparam logic [PC_W-1:0] A_LD_DUTY = 5'd14;
    localparam logic [PC_W-1:0] A_DIVD    = 5'd15;
    localparam logic [PC_W-1:0] A_DUTY    = 5'd16;
    localparam logic [PC_W-1:0] A_SETPH   = 5'd17;
    localparam logic [PC_W-1:0] A_OVF     = 5'd18;
    localparam logic [PC_W-1:0] A_TICK    = 5'd19;
    localparam logic [PC_W-1:0] A_OUT     = 5'd20;
    localparam logic [PC_W-1:0] A_RETURN  = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } pfdm_ctrl_t;

    // flags the sequencer branches on
    typedef struct packed {
        logic             in_fire;
        logic [CMD_W-1:0] cmd;
        logic             phase;
        logic             p_zero;
        logic             period_zero;
        logic             div_more;
        logic             acc_more;
        logic             out_full;
    } pfdm_status_t;

    function automatic pfdm_ctrl_t ucode(input logic [PC_W-1:0] addr);
        pfdm_ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_FETCH};
        unique case (addr)
            A_FETCH:   w = '{op: OP_FETCH,    cond: C_NO_INPUT,    target: A_FETCH};
            A_DISP_OV: w = '{op: OP_NOP,      cond: C_CMD_OVF,     target: A_OVF};
            A_DISP_TK: w = '{op: OP_NOP,      cond: C_CMD_TICK,    target: A_TICK};
            A_DISP_UN: w = '{op: OP_NOP,      cond: C_CMD_UNUSED,  target: A_OUT};
            A_ELAPSED: w = '{op: OP_ELAPSED,  cond: C_PHASE1,      target: A_FALL};
            A_PSUM:    w = '{op: OP_PSUM,     cond: C_NEVER,       target: A_FETCH};
            A_LD_FREQ: w = '{op: OP_LD_FREQ,  cond: C_P_ZERO,      target: A_SETPH};
            A_DIVF:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: A_DIVF};
            A_PUSH:    w = '{op: OP_PUSH,     cond: C_NEVER,       target: A_FETCH};
            A_ACC:     w = '{op: OP_ACC,      cond: C_ACC_MORE,    target: A_ACC};
            A_LD_AVG:  w = '{op: OP_LD_AVG,   cond: C_NEVER,       target: A_FETCH};
            A_DIVA:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: A_DIVA};
            A_AVG:     w = '{op: OP_AVG,      cond: C_ALWAYS,      target: A_SETPH};
            A_FALL:    w = '{op: OP_HIGH,     cond: C_NEVER,       target: A_FETCH};
            A_LD_DUTY: w = '{op: OP_LD_DUTY,  cond: C_PERIOD_ZERO, target: A_SETPH};
            A_DIVD:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: A_DIVD};
            A_DUTY:    w = '{op: OP_DUTY,     cond: C_NEVER,       target: A_FETCH};
            A_SETPH:   w = '{op: OP_SETPH,    cond: C_ALWAYS,      target: A_OUT};
            A_OVF:     w = '{op: OP_OVF,      cond: C_ALWAYS,      target: A_OUT};
            A_TICK:    w = '{op: OP_TICK,     cond: C_NEVER,       target: A_FETCH};
            A_OUT:     w = '{op: OP_OUT,      cond: C_OUT_FULL,    target: A_OUT};
            A_RETURN:  w = '{op: OP_NOP,      cond: C_ALWAYS,      target: A_FETCH};
            default:   w = '{op: OP_NOP,      cond: C_ALWAYS,      target: A_FETCH};
        endcase
        return w;
    endfunction

endpackage

@@ sv/pfdm_ifs.sv @@
// pfdm channel interfaces: input items, results and configuration writes.
// Depends on pfdm_pkg for field widths.
interface pfdm_item_if;
    logic                         valid;
    logic                         ready;
    logic [pfdm_pkg::CMD_W-1:0]    command;
    logic [pfdm_pkg::CNT_BITS-1:0] capture_count;
    modport source (output valid, command, capture_count, input ready);
    modport sink (input valid, command, capture_count, output ready);
endinterface

interface pfdm_result_if;
    logic                        valid;
    logic                        ready;
    logic [pfdm_pkg::FREQ_W-1:0] frequency_hz;
    logic [pfdm_pkg::DUTY_W-1:0] duty_percent;
    logic                        duty_valid;
    modport source (output valid, frequency_hz, duty_percent, duty_valid, input ready);
    modport sink (input valid, frequency_hz, duty_percent, duty_valid, output ready);
endinterface

interface pfdm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfdm_pkg::CFG_IDX_W-1:0] index;
    logic [pfdm_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/pfdm_seq.sv @@
// pfdm_seq: step counter and microcode table; picks the next step from the
// control word's jump condition. Depends on pfdm_pkg.
module pfdm_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfdm_pkg::pfdm_status_t status,
    output pfdm_pkg::pfdm_ctrl_t   ctrl
);

    logic [pfdm_pkg::PC_W-1:0] pc_reg;
    logic [pfdm_pkg::PC_W-1:0] pc_next;
    logic                      take;

    assign ctrl = pfdm_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            pfdm_pkg::C_NEVER:       take = 1'b0;
            pfdm_pkg::C_ALWAYS:      take = 1'b1;
            pfdm_pkg::C_NO_INPUT:    take = !status.in_fire;
            pfdm_pkg::C_CMD_OVF:     take = status.cmd == pfdm_pkg::CMD_OVF;
            pfdm_pkg::C_CMD_TICK:    take = status.cmd == pfdm_pkg::CMD_TICK;
            pfdm_pkg::C_CMD_UNUSED:  take = status.cmd != pfdm_pkg::CMD_EDGE;
            pfdm_pkg::C_PHASE1:      take = status.phase;
            pfdm_pkg::C_P_ZERO:      take = status.p_zero;
            pfdm_pkg::C_DIV_MORE:    take = status.div_more;
            pfdm_pkg::C_ACC_MORE:    take = status.acc_more;
            pfdm_pkg::C_PERIOD_ZERO: take = status.period_zero;
            pfdm_pkg::C_OUT_FULL:    take = status.out_full;
            default:                 take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= pfdm_pkg::A_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ sv/pfdm_div.sv @@
// pfdm_div: restoring divider, one quotient bit per step; the dividend is
// loaded left-aligned so the step count matches its width. Depends on pfdm_pkg.
module pfdm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           step,
    input  logic [pfdm_pkg::DIV_W-1:0]     dividend,
    input  logic [pfdm_pkg::TICK_W-1:0]    divisor,
    input  logic [pfdm_pkg::DIV_IT_W-1:0]  iters,
    output logic [pfdm_pkg::DIV_W-1:0]     quotient,
    output logic                           more
);

    logic [pfdm_pkg::DIV_W-1:0]    dvd_reg;
    logic [pfdm_pkg::TICK_W-1:0]   dsr_reg;
    logic [pfdm_pkg::TICK_W-1:0]   rem_reg;
    logic [pfdm_pkg::DIV_IT_W-1:0] cnt_reg;
    logic [pfdm_pkg::TICK_W:0]     shifted;
    logic [pfdm_pkg::TICK_W+1:0]   trial;
    logic                          fits;

    assign shifted  = {rem_reg, dvd_reg[pfdm_pkg::DIV_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits     = !trial[pfdm_pkg::TICK_W+1];
    assign quotient = dvd_reg;
    assign more     = cnt_reg != pfdm_pkg::DIV_IT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= iters;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= fits ? trial[pfdm_pkg::TICK_W-1:0] : shifted[pfdm_pkg::TICK_W-1:0];
            dvd_reg <= {dvd_reg[pfdm_pkg::DIV_W-2:0], fits};
        end
    end

endmodule

@@ sv/pfdm_dp.sv @@
// pfdm_dp: measurement datapath (edge timing, sample buffer, average, duty,
// timeout) driven by micro-ops. Depends on pfdm_pkg and pfdm_div.
module pfdm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfdm_pkg::pfdm_ctrl_t           ctrl,
    input  logic [pfdm_pkg::CNT_BITS-1:0]  cap,
    input  logic [pfdm_pkg::FREQ_W-1:0]    tps,
    input  logic [pfdm_pkg::LIMIT_W-1:0]   limit,
    output logic [pfdm_pkg::FREQ_W-1:0]    avg_freq,
    output logic [pfdm_pkg::DUTY_W-1:0]    duty,
    output logic                           duty_ok,
    output logic                           phase,
    output logic                           p_zero,
    output logic                           period_zero,
    output logic                           div_more,
    output logic                           acc_more
);

    localparam int AI = pfdm_pkg::AVG_IDX_W;
    localparam int AC = pfdm_pkg::AVG_CNT_W;
    localparam int TW = pfdm_pkg::TICK_W;

    logic                              phase_reg;
    logic [pfdm_pkg::CNT_BITS-1:0]     ovf_reg;
    logic [pfdm_pkg::CNT_BITS-1:0]     last_reg;
    logic [TW-1:0]                     high_reg;
    logic [TW-1:0]                     period_reg;
    logic [TW-1:0]                     e_reg;
    logic [TW-1:0]                     p_reg;
    logic [pfdm_pkg::MUL_W-1:0]        mul_reg;
    logic [pfdm_pkg::FREQ_W-1:0]       samples [pfdm_pkg::AVG_DEPTH];
    logic [AI-1:0]                     widx_reg;
    logic [AC-1:0]                     scnt_reg;
    logic [pfdm_pkg::SUM_W-1:0]        acc_reg;
    logic [AC-1:0]                     aidx_reg;
    logic [pfdm_pkg::FREQ_W-1:0]       avg_reg;
    logic [pfdm_pkg::DUTY_W-1:0]       duty_reg;
    logic                              dvalid_reg;
    logic [pfdm_pkg::LIMIT_W-1:0]      idle_reg;

    logic [TW-1:0]                     elapsed;
    logic [TW:0]                       psum;
    logic [pfdm_pkg::LIMIT_W-1:0]      idle_inc;
    logic                              div_load;
    logic [pfdm_pkg::DIV_W-1:0]        div_dvd;
    logic [TW-1:0]                     div_dsr;
    logic [pfdm_pkg::DIV_IT_W-1:0]     div_it;
    logic [pfdm_pkg::DIV_W-1:0]        quot;

    // overflow count forms the upper half; wraps when the capture is behind
    assign elapsed  = {ovf_reg, cap} - TW'(last_reg);
    assign psum     = {1'b0, high_reg} + {1'b0, e_reg};
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    assign avg_freq    = avg_reg;
    assign duty        = duty_reg;
    assign duty_ok     = dvalid_reg;
    assign phase       = phase_reg;
    assign p_zero      = p_reg == '0;
    assign period_zero = period_reg == '0;
    assign acc_more    = AC'(aidx_reg + 1'b1) != scnt_reg;

    always_comb
    begin
        div_load = 1'b1;
        div_dvd  = {tps, (pfdm_pkg::DIV_W - pfdm_pkg::FREQ_W)'(0)};
        div_dsr  = p_reg;
        div_it   = pfdm_pkg::DIV_IT_W'(pfdm_pkg::FREQ_W);
        case (ctrl.op)
            pfdm_pkg::OP_LD_FREQ:
            begin
                div_load = 1'b1;
            end
            pfdm_pkg::OP_LD_AVG:
            begin
                div_dvd = {acc_reg, (pfdm_pkg::DIV_W - pfdm_pkg::SUM_W)'(0)};
                div_dsr = TW'(scnt_reg);
                div_it  = pfdm_pkg::DIV_IT_W'(pfdm_pkg::SUM_W);
            end
            pfdm_pkg::OP_LD_DUTY:
            begin
                div_dvd = pfdm_pkg::DIV_W'(mul_reg);
                div_dsr = period_reg;
                div_it  = pfdm_pkg::DIV_IT_W'(pfdm_pkg::DIV_W);
            end
            default:
            begin
                div_load = 1'b0;
            end
        endcase
    end

    pfdm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .step     (ctrl.op == pfdm_pkg::OP_DIV_STEP),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .iters    (div_it),
        .quotient (quot),
        .more     (div_more)
    );

    // sample buffer: entries past the fill count are never read
    always_ff @(posedge clk)
    begin
        if (ctrl.op == pfdm_pkg::OP_PUSH)
            samples[widx_reg] <= quot[pfdm_pkg::FREQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            ovf_reg    <= '0;
            last_reg   <= '0;
            high_reg   <= '0;
            period_reg <= '0;
            e_reg      <= '0;
            p_reg      <= '0;
            mul_reg    <= '0;
            widx_reg   <= '0;
            scnt_reg   <= '0;
            acc_reg    <= '0;
            aidx_reg   <= '0;
            avg_reg    <= '0;
            duty_reg   <= '0;
            dvalid_reg <= 1'b0;
            idle_reg   <= '0;
        end
        else
        begin
            case (ctrl.op)
                pfdm_pkg::OP_ELAPSED:
                begin
                    e_reg    <= elapsed;
                    last_reg <= cap;
                    ovf_reg  <= '0;
                    idle_reg <= '0;
                end
                pfdm_pkg::OP_PSUM:
                begin
                    p_reg <= psum[TW] ? '1 : psum[TW-1:0];
                end
                pfdm_pkg::OP_PUSH:
                begin
                    widx_reg <= (widx_reg == AI'(pfdm_pkg::AVG_DEPTH - 1)) ? '0 : widx_reg + 1'b1;
                    if (scnt_reg != AC'(pfdm_pkg::AVG_DEPTH))
                        scnt_reg <= scnt_reg + 1'b1;
                    period_reg <= p_reg;
                    acc_reg    <= '0;
                    aidx_reg   <= '0;
                end
                pfdm_pkg::OP_ACC:
                begin
                    acc_reg  <= acc_reg + pfdm_pkg::SUM_W'(samples[aidx_reg[AI-1:0]]);
                    aidx_reg <= aidx_reg + 1'b1;
                end
                pfdm_pkg::OP_AVG:
                begin
                    avg_reg <= quot[pfdm_pkg::FREQ_W-1:0];
                end
                pfdm_pkg::OP_HIGH:
                begin
                    high_reg <= e_reg;
                    mul_reg  <= pfdm_pkg::MUL_W'(e_reg) * pfdm_pkg::MUL_W'(pfdm_pkg::DUTY_SCALE);
                end
                pfdm_pkg::OP_DUTY:
                begin
                    duty_reg   <= (quot > pfdm_pkg::DIV_W'(pfdm_pkg::DUTY_SCALE))
                                  ? pfdm_pkg::DUTY_W'(pfdm_pkg::DUTY_SCALE)
                                  : quot[pfdm_pkg::DUTY_W-1:0];
                    dvalid_reg <= 1'b1;
                end
                pfdm_pkg::OP_SETPH:
                begin
                    phase_reg <= !phase_reg;
                end
                pfdm_pkg::OP_OVF:
                begin
                    if (ovf_reg != '1)
                        ovf_reg <= ovf_reg + 1'b1;
                end
                pfdm_pkg::OP_TICK:
                begin
                    // timeout: signal declared absent
                    if (idle_inc >= limit)
                    begin
                        avg_reg    <= '0;
                        dvalid_reg <= 1'b0;
                        idle_reg   <= '0;
                    end
                    else
                    begin
                        idle_reg <= idle_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ sv/pulse_frequency_duty_meter_unit.sv @@
// pulse_frequency_duty_meter_unit: top level; configuration registers, input
// latch and result register around the microcoded sequencer and datapath.
// Depends on pfdm_pkg, pfdm_ifs, pfdm_seq, pfdm_dp.
//
//   channel  dir  ready         payload
//   item     in   step FETCH    command, capture_count
//   result   out  sink drives   frequency_hz, duty_percent, duty_valid
//   cfg      in   always high   index, data
//
// Overflow, timeout-tick and unused-command items skip the divider; a rising
// edge divides for frequency and average and sums each filled average entry,
// a falling edge for duty. The serial divider gives one quotient bit per cycle.
// Reset clears all measurement state; the average buffer is read only where filled.
// A stalled result holds the sequencer at its output step; the next item is
// taken once the result has moved to the output register.
module pulse_frequency_duty_meter_unit (
    input  logic          clk,
    input  logic          rst_n,
    pfdm_item_if.sink     item,
    pfdm_result_if.source result,
    pfdm_cfg_if.sink      cfg
);

    pfdm_pkg::pfdm_ctrl_t   ctrl;
    pfdm_pkg::pfdm_status_t status;

    logic [pfdm_pkg::FREQ_W-1:0]   tps_reg;
    logic [pfdm_pkg::LIMIT_W-1:0]  limit_reg;
    logic [pfdm_pkg::CMD_W-1:0]    cmd_reg;
    logic [pfdm_pkg::CNT_BITS-1:0] cap_reg;
    logic                          out_valid_reg;
    logic [pfdm_pkg::FREQ_W-1:0]   freq_reg;
    logic [pfdm_pkg::DUTY_W-1:0]   duty_out_reg;
    logic                          dvalid_out_reg;

    logic [pfdm_pkg::FREQ_W-1:0]   avg_freq;
    logic [pfdm_pkg::DUTY_W-1:0]   duty;
    logic                          duty_ok;
    logic                          in_fire;
    logic                          out_full;
    logic                          out_load;

    assign item.ready = ctrl.op == pfdm_pkg::OP_FETCH;
    assign in_fire    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign out_full   = out_valid_reg && !result.ready;
    assign out_load   = (ctrl.op == pfdm_pkg::OP_OUT) && !out_full;

    assign result.valid        = out_valid_reg;
    assign result.frequency_hz = freq_reg;
    assign result.duty_percent = duty_out_reg;
    assign result.duty_valid   = dvalid_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= pfdm_pkg::TPS_RESET;
            limit_reg <= pfdm_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfdm_pkg::CFG_TPS:   tps_reg   <= cfg.data;
                pfdm_pkg::CFG_LIMIT: limit_reg <= cfg.data[pfdm_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= pfdm_pkg::CMD_EDGE;
            cap_reg <= '0;
        end
        else if (in_fire)
        begin
            cmd_reg <= item.command;
            cap_reg <= item.capture_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // duty field reads zero while the measurement is invalid
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            freq_reg       <= avg_freq;
            duty_out_reg   <= duty_ok ? duty : '0;
            dvalid_out_reg <= duty_ok;
        end
    end

    assign status.in_fire  = in_fire;
    assign status.cmd      = cmd_reg;
    assign status.out_full = out_full;

    pfdm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    pfdm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cap         (cap_reg),
        .tps         (tps_reg),
        .limit       (limit_reg),
        .avg_freq    (avg_freq),
        .duty        (duty),
        .duty_ok     (duty_ok),
        .phase       (status.phase),
        .p_zero      (status.p_zero),
        .period_zero (status.period_zero),
        .div_more    (status.div_more),
        .acc_more    (status.acc_more)
    );

endmodule
